FILE: hw/rtl/fmp_pkg.sv
// Shared constants, types and modular helpers for the Fibonacci mod-prime block
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

    localparam int INDEX_BITS_DEF = 63;
    localparam int VAL_W          = 30;

    localparam logic [VAL_W-1:0] FIB_PRIME = VAL_W'(1000000007);

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [31:0] FIB_MU  = MU_FULL[31:0];

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_ISSUE,
        FS_WAIT,
        FS_UPDATE,
        FS_DONE
    } t_fib_state;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_PROD,
        MM_QUOT,
        MM_BACK
    } t_mm_phase;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } t_mm_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } t_mm_rsp;

    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        logic [VAL_W:0] sum;
        logic [VAL_W:0] red;
        sum = {1'b0, x} + {1'b0, y};
        red = sum - {1'b0, FIB_PRIME};
        if (sum >= {1'b0, FIB_PRIME}) begin
            return red[VAL_W-1:0];
        end
        return sum[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fibonacci_mod_prime_matrix_power.sv
// Fibonacci F(n) mod 1000000007 by MSB-first 2x2 matrix power on one shared modular multiplier
// A new index is accepted only in idle; busy is high for the whole item.
// Each exponent bit costs four modular products on the shared multiplier plus one update.
// Reset (synchronous, active low) returns the sequencer to idle; no state is kept between items.
// The result is shown for one cycle with o_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module fibonacci_mod_prime_matrix_power #(
    parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [INDEX_BITS-1:0]         i_fib_index,
    output logic                          o_valid,
    output logic [fmp_pkg::VAL_W-1:0]     o_fib_value
);

    localparam int CNT_W = $clog2(INDEX_BITS + 1);
    localparam int VW    = fmp_pkg::VAL_W;

    fmp_pkg::t_fib_state r_state;
    fmp_pkg::t_fib_state n_state;

    logic [INDEX_BITS-1:0] r_n;
    logic [INDEX_BITS-1:0] n_n;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [1:0]            r_sel;
    logic [1:0]            n_sel;

    // symmetric matrix [[a, b], [b, d]]
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic [VW-1:0] r_d;
    logic [VW-1:0] n_a;
    logic [VW-1:0] n_b;
    logic [VW-1:0] n_d;
    logic [VW-1:0] r_prd [4];

    logic [VW-1:0] sq_a;
    logic [VW-1:0] sq_b;
    logic [VW-1:0] sq_d;
    logic [VW-1:0] sum_ad;

    fmp_pkg::t_mm_req mm_req;
    fmp_pkg::t_mm_rsp mm_rsp;

    fmp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            fmp_pkg::FS_IDLE: begin
                if (start) begin
                    n_state = fmp_pkg::FS_ISSUE;
                end
            end
            fmp_pkg::FS_ISSUE: n_state = fmp_pkg::FS_WAIT;
            fmp_pkg::FS_WAIT: begin
                if (mm_rsp.done) begin
                    n_state = (r_sel == 2'd3) ? fmp_pkg::FS_UPDATE : fmp_pkg::FS_ISSUE;
                end
            end
            fmp_pkg::FS_UPDATE: begin
                n_state = (r_cnt == CNT_W'(1)) ? fmp_pkg::FS_DONE : fmp_pkg::FS_ISSUE;
            end
            fmp_pkg::FS_DONE: n_state = fmp_pkg::FS_IDLE;
            default:          n_state = fmp_pkg::FS_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != fmp_pkg::FS_IDLE);
        o_valid     = (r_state == fmp_pkg::FS_DONE);
        o_fib_value = r_b;
    end

    // operands for the four products of a squaring: a*a, b*b, d*d, b*(a+d)
    always_comb begin
        sum_ad       = fmp_pkg::add_mod(r_a, r_d);
        mm_req.start = (r_state == fmp_pkg::FS_ISSUE);
        case (r_sel)
            2'd0: begin
                mm_req.x = r_a;
                mm_req.y = r_a;
            end
            2'd1: begin
                mm_req.x = r_b;
                mm_req.y = r_b;
            end
            2'd2: begin
                mm_req.x = r_d;
                mm_req.y = r_d;
            end
            default: begin
                mm_req.x = r_b;
                mm_req.y = sum_ad;
            end
        endcase
    end

    always_comb begin
        sq_a  = fmp_pkg::add_mod(r_prd[0], r_prd[1]);
        sq_b  = r_prd[3];
        sq_d  = fmp_pkg::add_mod(r_prd[1], r_prd[2]);
        n_a   = r_a;
        n_b   = r_b;
        n_d   = r_d;
        n_n   = r_n;
        n_cnt = r_cnt;
        n_sel = r_sel;
        case (r_state)
            fmp_pkg::FS_IDLE: begin
                n_a   = VW'(1);
                n_b   = '0;
                n_d   = VW'(1);
                n_n   = i_fib_index;
                n_cnt = CNT_W'(INDEX_BITS);
                n_sel = 2'd0;
            end
            fmp_pkg::FS_WAIT: begin
                if (mm_rsp.done) begin
                    n_sel = r_sel + 2'd1;
                end
            end
            fmp_pkg::FS_UPDATE: begin
                if (r_n[INDEX_BITS-1]) begin
                    // times [[1,1],[1,0]]
                    n_a = fmp_pkg::add_mod(sq_a, sq_b);
                    n_b = sq_a;
                    n_d = sq_b;
                end else begin
                    n_a = sq_a;
                    n_b = sq_b;
                    n_d = sq_d;
                end
                n_n   = r_n << 1;
                n_cnt = r_cnt - CNT_W'(1);
                n_sel = 2'd0;
            end
            default: begin
                n_sel = r_sel;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmp_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_d   <= n_d;
        r_n   <= n_n;
        r_cnt <= n_cnt;
        r_sel <= n_sel;
        if (r_state == fmp_pkg::FS_WAIT && mm_rsp.done) begin
            r_prd[r_sel] <= mm_rsp.result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fmp_modmul.sv
// Shared multiplier with Barrett reduction modulo 1000000007; a new product is taken only when idle
`timescale 1ns / 1ps
`default_nettype none

module fmp_modmul (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire fmp_pkg::t_mm_req i_req,
    output fmp_pkg::t_mm_rsp      o_rsp
);

    fmp_pkg::t_mm_phase r_phase;
    fmp_pkg::t_mm_phase n_phase;

    logic [63:0] r_prod;
    logic [63:0] n_prod;
    logic [31:0] r_lo;
    logic [31:0] n_lo;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] diff;
    logic [31:0] diff_p;
    logic [31:0] diff_2p;
    logic [31:0] red;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            fmp_pkg::MM_IDLE: begin
                if (i_req.start) begin
                    n_phase = fmp_pkg::MM_PROD;
                end
            end
            fmp_pkg::MM_PROD: n_phase = fmp_pkg::MM_QUOT;
            fmp_pkg::MM_QUOT: n_phase = fmp_pkg::MM_BACK;
            fmp_pkg::MM_BACK: n_phase = fmp_pkg::MM_IDLE;
            default:          n_phase = fmp_pkg::MM_IDLE;
        endcase
    end

    // operand select for the single multiplier
    always_comb begin
        mul_a = {2'b00, i_req.x};
        mul_b = {2'b00, i_req.y};
        n_lo  = r_lo;
        case (r_phase)
            fmp_pkg::MM_PROD: begin
                mul_a = {1'b0, r_prod[59:29]};
                mul_b = fmp_pkg::FIB_MU;
                n_lo  = r_prod[31:0];
            end
            fmp_pkg::MM_QUOT: begin
                mul_a = {1'b0, r_prod[61:31]};
                mul_b = {2'b00, fmp_pkg::FIB_PRIME};
            end
            default: begin
                mul_a = {2'b00, i_req.x};
                mul_b = {2'b00, i_req.y};
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    // remainder is below 3p, at most two subtractions of p
    always_comb begin
        diff    = r_lo - r_prod[31:0];
        diff_p  = diff - {2'b00, fmp_pkg::FIB_PRIME};
        diff_2p = diff - {1'b0, fmp_pkg::FIB_PRIME, 1'b0};
        if (diff >= {1'b0, fmp_pkg::FIB_PRIME, 1'b0}) begin
            red = diff_2p;
        end else if (diff >= {2'b00, fmp_pkg::FIB_PRIME}) begin
            red = diff_p;
        end else begin
            red = diff;
        end
    end

    always_comb begin
        o_rsp.done   = (r_phase == fmp_pkg::MM_BACK);
        o_rsp.result = red[fmp_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fmp_pkg::MM_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_lo   <= n_lo;
    end

endmodule

`default_nettype wire

FILE: tb/tb_fibonacci_mod_prime_matrix_power.sv
// Testbench for the Fibonacci mod-prime block: directed table, random indices, result check
`timescale 1ns / 1ps

module tb_fibonacci_mod_prime_matrix_power;

    localparam int IDX_W      = fmp_pkg::INDEX_BITS_DEF;
    localparam int VAL_W      = fmp_pkg::VAL_W;
    localparam int RAND_ITEMS = 274;
    localparam int ROWS       = 16;

    typedef logic [3:0][VAL_W-1:0] t_mat;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             known;
        logic [VAL_W-1:0] val;
    } t_fib_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [IDX_W-1:0] i_fib_index = '0;
    logic             busy;
    logic             o_valid;
    logic [VAL_W-1:0] o_fib_value;

    logic [VAL_W-1:0] fib_expected [$];
    int               mismatches = 0;
    bit               no_idle = 1'b0;

    t_fib_row fib_rows [ROWS] = '{
        '{63'd0,  1'b1, 30'd0},
        '{63'd1,  1'b1, 30'd1},
        '{63'd2,  1'b1, 30'd1},
        '{63'd3,  1'b1, 30'd2},
        '{63'd10, 1'b1, 30'd55},
        '{63'd12, 1'b1, 30'd144},
        '{63'd30, 1'b1, 30'd832040},
        '{63'd40, 1'b1, 30'd102334155},
        '{63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
        '{63'h4000_0000_0000_0000, 1'b0, 30'd0},
        '{63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 30'd0},
        '{63'h5555_5555_5555_5555, 1'b0, 30'd0},
        '{63'd1000000007, 1'b0, 30'd0},
        '{63'd2000000016, 1'b0, 30'd0},
        '{63'h0000_0000_7FFF_FFFF, 1'b0, 30'd0},
        '{63'h0000_0001_0000_0000, 1'b0, 30'd0}
    };

    fibonacci_mod_prime_matrix_power DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_fib_index (i_fib_index),
        .o_valid     (o_valid),
        .o_fib_value (o_fib_value)
    );

    function automatic t_mat mat_mul_mod(input t_mat a, input t_mat b);
        t_mat        r;
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] prime;
        prime = 64'(fmp_pkg::FIB_PRIME);
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                p0 = (64'(a[2*i]) * 64'(b[j])) % prime;
                p1 = (64'(a[2*i+1]) * 64'(b[2+j])) % prime;
                p0 = (p0 + p1) % prime;
                r[2*i+j] = p0[VAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] fib_mod_prime(input logic [IDX_W-1:0] n);
        t_mat m;
        t_mat q;
        q = {30'd0, 30'd1, 30'd1, 30'd1};
        m = {30'd1, 30'd0, 30'd0, 30'd1};
        for (int b = IDX_W - 1; b >= 0; b--) begin
            m = mat_mul_mod(m, m);
            if (n[b]) begin
                m = mat_mul_mod(m, q);
            end
        end
        return m[1];
    endfunction

    task automatic issue_index(input logic [IDX_W-1:0] idx, input logic known,
                               input logic [VAL_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_fib_index <= idx;
        do @(posedge i_clk); while (busy);
        fib_expected.push_back(known ? val : fib_mod_prime(idx));
    endtask

    function automatic logic [IDX_W-1:0] random_index();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return IDX_W'($urandom_range(0, 200));
            1: return full[IDX_W-1:0];
            2: return full[IDX_W-1:0] >> $urandom_range(0, IDX_W - 1);
            default: begin
                full = 64'd1 << $urandom_range(0, IDX_W - 1);
                if ($urandom_range(0, 1)) begin
                    full = full - 64'd1;
                end
                return full[IDX_W-1:0];
            end
        endcase
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_fibonacci_mod_prime_matrix_power NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (fib_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: fib_value %0d", o_fib_value);
                end
            end else if (o_fib_value !== fib_expected[0]) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("fib_value mismatch: expected %0d got %0d",
                             fib_expected[0], o_fib_value);
                end
                void'(fib_expected.pop_front());
            end else begin
                void'(fib_expected.pop_front());
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (fib_rows[r]) begin
            issue_index(fib_rows[r].idx, fib_rows[r].known, fib_rows[r].val);
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 16 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (k == RAND_ITEMS / 2) begin
                // drain the block before going on
                start <= 1'b0;
                do @(posedge i_clk); while (fib_expected.size() != 0);
            end
            issue_index(random_index(), 1'b0, '0);
        end
        start <= 1'b0;

        while (fib_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_fibonacci_mod_prime_matrix_power OK");
        end else begin
            $display("tb_fibonacci_mod_prime_matrix_power NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fmp_pkg.sv
hw/rtl/fmp_modmul.sv
hw/rtl/fibonacci_mod_prime_matrix_power.sv
tb/tb_fibonacci_mod_prime_matrix_power.sv
